### hdl/rrtc_pkg.sv
package rrtc_pkg;

    localparam int MAX_MEMBERS = 8;
    localparam int SLOT_W      = $clog2(MAX_MEMBERS);
    localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
    localparam int ID_W        = 8;
    localparam int CRED_W      = 15;
    localparam int PTS_W       = 16;
    localparam int ACT_W       = 3;
    localparam int STAT_W      = 3;
    localparam int IDX_W       = 3;
    localparam int POS_W       = 3;
    localparam int CNTO_W      = 4;

    localparam logic [CRED_W-1:0] CREDITS_RESET = CRED_W'(4);

    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SPEND  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_END    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd5;

    localparam logic [STAT_W-1:0] STS_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STS_NO_MEMBER  = 3'd1;
    localparam logic [STAT_W-1:0] STS_NOT_MEMBER = 3'd2;
    localparam logic [STAT_W-1:0] STS_NOT_HOLDER = 3'd3;
    localparam logic [STAT_W-1:0] STS_FULL       = 3'd4;
    localparam logic [STAT_W-1:0] STS_SHORT      = 3'd5;
    localparam logic [STAT_W-1:0] STS_BAD_COST   = 3'd6;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

### hdl/rrtc_cell.sv
module rrtc_cell
    import rrtc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic [ID_W-1:0] i_load_id,
    input  logic [ID_W-1:0] i_next_id,
    input  logic [ID_W-1:0] i_key,
    output logic [ID_W-1:0] o_id,
    output logic            o_match
);

    logic [ID_W-1:0] r_id;
    logic [ID_W-1:0] n_id;

    always_comb begin
        n_id = r_id;
        if (i_ctl.load) begin
            n_id = i_load_id;
        end else if (i_ctl.shift) begin
            n_id = i_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id <= '0;
        end else begin
            r_id <= n_id;
        end
    end

    assign o_id    = r_id;
    assign o_match = (r_id == i_key) && (i_key != '0);

endmodule

### hdl/round_robin_turn_credit_scheduler_core.sv
// Channel   Direction  Handshake                  Beat
// input     in         i_in_valid / o_in_ready    action, user_id, points, slot_index
// output    out        o_out_valid / i_out_ready  status, slot_user, holder_user,
//                                                 credits_left, member_count, holder_position
// config    in         i_cfg_we                   credits_per_turn
//
// Each beat passes in turn through capture, decide, apply, and result register load.
// The member table is a chain of eight cells that match in parallel and compact by
// shifting toward slot zero. The next beat is accepted once the result register has
// been loaded. A stalled output holds the block in its last step.
// Synchronous active-low reset clears table, counters and credits and sets the default budget.
module round_robin_turn_credit_scheduler_core
    import rrtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ID_W-1:0]   i_user_id,
    input  logic [PTS_W-1:0]  i_points,
    input  logic [IDX_W-1:0]  i_slot_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_slot_user,
    output logic [ID_W-1:0]   o_holder_user,
    output logic [CRED_W-1:0] o_credits_left,
    output logic [CNTO_W-1:0] o_member_count,
    output logic [POS_W-1:0]  o_holder_position,
    input  logic              i_cfg_we,
    input  logic [CRED_W-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [ACT_W-1:0]  r_action;
    logic [ID_W-1:0]   r_user;
    logic [PTS_W-1:0]  r_points;
    logic [IDX_W-1:0]  r_slot_idx;
    logic [CRED_W-1:0] r_cpt;
    logic [CNT_W-1:0]  r_total;
    logic [CNT_W-1:0]  n_total;
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] n_cur;
    logic [CRED_W-1:0] r_credit;
    logic [CRED_W-1:0] n_credit;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic              r_do;
    logic              n_do;
    logic [SLOT_W-1:0] r_pos;
    logic [SLOT_W-1:0] w_pos;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [ID_W-1:0]   r_out_slot_user;
    logic [ID_W-1:0]   r_out_holder;
    logic [CRED_W-1:0] r_out_credits;
    logic [CNTO_W-1:0] r_out_count;
    logic [POS_W-1:0]  r_out_pos;

    logic [ID_W-1:0]   w_cell_id [MAX_MEMBERS];
    logic [MAX_MEMBERS-1:0] w_match;
    t_cell_ctl         w_ctl [MAX_MEMBERS];
    logic              w_found;
    logic [ID_W-1:0]   w_holder;
    logic [STAT_W-1:0] w_gate;
    logic [STAT_W-1:0] w_spend_gate;
    logic              w_apply_add;
    logic              w_apply_rem;
    logic [CNT_W-1:0]  w_total_dec;
    logic [CNT_W-1:0]  w_cur_inc;
    logic              w_out_load;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_MEMBERS; gi++) begin : g_cell
            assign w_ctl[gi].load  = w_apply_add && (r_total == CNT_W'(gi));
            assign w_ctl[gi].shift = w_apply_rem && (SLOT_W'(gi) >= r_pos);
            if (gi == MAX_MEMBERS - 1) begin : g_last
                rrtc_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl[gi]),
                    .i_load_id (r_user),
                    .i_next_id ({ID_W{1'b0}}),
                    .i_key     (r_user),
                    .o_id      (w_cell_id[gi]),
                    .o_match   (w_match[gi])
                );
            end else begin : g_mid
                rrtc_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl[gi]),
                    .i_load_id (r_user),
                    .i_next_id (w_cell_id[gi+1]),
                    .i_key     (r_user),
                    .o_id      (w_cell_id[gi]),
                    .o_match   (w_match[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < MAX_MEMBERS; i++) begin
            if (w_match[i]) begin
                w_pos = w_pos | SLOT_W'(i);
            end
        end
    end

    assign w_found  = |w_match;
    assign w_holder = w_cell_id[r_cur];

    always_comb begin
        if (r_user == '0) begin
            w_gate = STS_NO_MEMBER;
        end else if (!w_found) begin
            w_gate = STS_NOT_MEMBER;
        end else if (w_holder != r_user) begin
            w_gate = STS_NOT_HOLDER;
        end else begin
            w_gate = STS_OK;
        end
    end

    always_comb begin
        if (w_gate != STS_OK) begin
            w_spend_gate = w_gate;
        end else if (r_points[PTS_W-1]) begin
            w_spend_gate = STS_BAD_COST;
        end else if (r_points[CRED_W-1:0] > r_credit) begin
            w_spend_gate = STS_SHORT;
        end else begin
            w_spend_gate = STS_OK;
        end
    end

    always_comb begin
        n_status = STS_OK;
        n_do     = 1'b0;
        unique case (r_action)
            ACT_ADD: begin
                if (r_user == '0) begin
                    n_status = STS_NO_MEMBER;
                end else if (w_found) begin
                    n_status = STS_OK;
                end else if (r_total >= CNT_W'(MAX_MEMBERS)) begin
                    n_status = STS_FULL;
                end else begin
                    n_do = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (r_user == '0) begin
                    n_status = STS_NO_MEMBER;
                end else if (!w_found) begin
                    n_status = STS_NOT_MEMBER;
                end else begin
                    n_do = 1'b1;
                end
            end
            ACT_CHECK: begin
                n_status = w_spend_gate;
            end
            ACT_SPEND: begin
                n_status = w_spend_gate;
                n_do     = (w_spend_gate == STS_OK);
            end
            ACT_END: begin
                n_status = w_gate;
                n_do     = (w_gate == STS_OK);
            end
            default: begin
                n_status = STS_OK;
            end
        endcase
    end

    assign w_apply_add = (r_state == S_APPLY) && r_do && (r_action == ACT_ADD);
    assign w_apply_rem = (r_state == S_APPLY) && r_do && (r_action == ACT_REMOVE);
    assign w_total_dec = r_total - CNT_W'(1);
    assign w_cur_inc   = {1'b0, r_cur} + CNT_W'(1);

    always_comb begin
        n_total  = r_total;
        n_cur    = r_cur;
        n_credit = r_credit;
        if ((r_state == S_APPLY) && r_do) begin
            unique case (r_action)
                ACT_ADD: begin
                    n_total = r_total + CNT_W'(1);
                    if (r_total == '0) begin
                        n_cur    = '0;
                        n_credit = r_cpt;
                    end
                end
                ACT_REMOVE: begin
                    n_total = w_total_dec;
                    if (w_total_dec == '0) begin
                        n_cur    = '0;
                        n_credit = '0;
                    end else if (r_pos < r_cur) begin
                        n_cur = r_cur - SLOT_W'(1);
                    end else if (r_pos == r_cur) begin
                        if ({1'b0, r_cur} >= w_total_dec) begin
                            n_cur = '0;
                        end
                        n_credit = r_cpt;
                    end
                end
                ACT_SPEND: begin
                    n_credit = r_credit - r_points[CRED_W-1:0];
                end
                ACT_END: begin
                    n_cur    = (w_cur_inc == r_total) ? '0 : w_cur_inc[SLOT_W-1:0];
                    n_credit = r_cpt;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_out_load = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE: n_state = S_APPLY;
            S_APPLY:  n_state = S_FINISH;
            S_FINISH: if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cpt       <= CREDITS_RESET;
            r_total     <= '0;
            r_cur       <= '0;
            r_credit    <= '0;
            r_do        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_cur    <= n_cur;
            r_credit <= n_credit;
            if (i_cfg_we) begin
                r_cpt <= i_cfg_data;
            end
            if (r_state == S_DECIDE) begin
                r_do <= n_do;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_action   <= i_action;
            r_user     <= i_user_id;
            r_points   <= i_points;
            r_slot_idx <= i_slot_index;
        end
        if (r_state == S_DECIDE) begin
            r_status <= n_status;
            r_pos    <= w_pos;
        end
        if (w_out_load) begin
            r_out_status    <= r_status;
            r_out_slot_user <= w_cell_id[r_slot_idx];
            r_out_holder    <= w_holder;
            r_out_credits   <= r_credit;
            r_out_count     <= CNTO_W'(r_total);
            r_out_pos       <= POS_W'(r_cur);
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_slot_user       = r_out_slot_user;
    assign o_holder_user     = r_out_holder;
    assign o_credits_left    = r_out_credits;
    assign o_member_count    = r_out_count;
    assign o_holder_position = r_out_pos;

endmodule

### hdl/rrtc_checker.sv
module rrtc_checker
    import rrtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic [STAT_W-1:0] o_status,
    input  logic [ID_W-1:0]   o_holder_user,
    input  logic [CRED_W-1:0] o_credits_left,
    input  logic [CNTO_W-1:0] o_member_count,
    input  logic [POS_W-1:0]  o_holder_position
);

    a_in_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input accepted a second beat while one was in flight.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("Stalled output beat changed.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_member_count <= CNTO_W'(MAX_MEMBERS))
        else $error("Member count beyond table size.");

    a_empty_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_member_count == '0) |->
            (o_holder_user == '0) && (o_credits_left == '0) && (o_holder_position == '0))
        else $error("Empty table reports a holder or credits.");

    a_holder_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_member_count != '0) |->
            (CNTO_W'(o_holder_position) < o_member_count) && (o_holder_user != '0))
        else $error("Holder position outside the table.");

endmodule

bind round_robin_turn_credit_scheduler_core rrtc_checker u_rrtc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_holder_user     (o_holder_user),
    .o_credits_left    (o_credits_left),
    .o_member_count    (o_member_count),
    .o_holder_position (o_holder_position)
);

### bench/round_robin_turn_credit_scheduler_core_test.sv
`timescale 1ns / 100ps

module round_robin_turn_credit_scheduler_core_test;
    import rrtc_pkg::*;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  user_id;
        logic [PTS_W-1:0] points;
        logic [IDX_W-1:0] slot_index;
        bit               aim_holder;
        bit               aim_points;
    } t_sched_cmd;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   slot_user;
        logic [ID_W-1:0]   holder_user;
        logic [CRED_W-1:0] credits_left;
        logic [CNTO_W-1:0] member_count;
        logic [POS_W-1:0]  holder_position;
    } t_sched_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [ACT_W-1:0]  i_action = '0;
    logic [ID_W-1:0]   i_user_id = '0;
    logic [PTS_W-1:0]  i_points = '0;
    logic [IDX_W-1:0]  i_slot_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [ID_W-1:0]   o_slot_user;
    logic [ID_W-1:0]   o_holder_user;
    logic [CRED_W-1:0] o_credits_left;
    logic [CNTO_W-1:0] o_member_count;
    logic [POS_W-1:0]  o_holder_position;
    logic              i_cfg_we = 1'b0;
    logic [CRED_W-1:0] i_cfg_data = '0;

    t_sched_cmd    cmd_queue[$];
    t_sched_result expected_q[$];
    logic          in_fire = 1'b0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            fail_count = 0;

    logic [ID_W-1:0]   roster [MAX_MEMBERS] = '{default: '0};
    int                roster_len = 0;
    int                turn_pos = 0;
    int                balance = 0;
    logic [CRED_W-1:0] turn_budget = CREDITS_RESET;

    round_robin_turn_credit_scheduler_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (i_action),
        .i_user_id         (i_user_id),
        .i_points          (i_points),
        .i_slot_index      (i_slot_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_slot_user       (o_slot_user),
        .o_holder_user     (o_holder_user),
        .o_credits_left    (o_credits_left),
        .o_member_count    (o_member_count),
        .o_holder_position (o_holder_position),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Applies one beat to the scheduler shadow and returns what the block should report.
    function automatic t_sched_result apply_command(input logic [ACT_W-1:0] act,
                                                    input logic [ID_W-1:0] uid,
                                                    input logic [PTS_W-1:0] pts,
                                                    input logic [IDX_W-1:0] idx);
        t_sched_result     res;
        logic [STAT_W-1:0] st;
        logic [STAT_W-1:0] gate;
        int                found;
        int                holder;
        int                i;
        bit                was_holder;
        st = STS_OK;
        found = -1;
        for (i = 0; i < roster_len; i++) begin
            if (uid != '0 && roster[i] == uid) begin
                found = i;
            end
        end
        holder = (turn_pos < roster_len) ? int'(roster[turn_pos]) : 0;
        if (uid == '0) begin
            gate = STS_NO_MEMBER;
        end else if (found < 0) begin
            gate = STS_NOT_MEMBER;
        end else if (holder != int'(uid)) begin
            gate = STS_NOT_HOLDER;
        end else begin
            gate = STS_OK;
        end
        case (act)
            ACT_ADD: begin
                if (uid == '0) begin
                    st = STS_NO_MEMBER;
                end else if (found >= 0) begin
                    st = STS_OK;
                end else if (roster_len >= MAX_MEMBERS) begin
                    st = STS_FULL;
                end else begin
                    if (roster_len == 0) begin
                        turn_pos = 0;
                        balance = int'(turn_budget);
                    end
                    roster[roster_len] = uid;
                    roster_len++;
                end
            end
            ACT_REMOVE: begin
                if (uid == '0) begin
                    st = STS_NO_MEMBER;
                end else if (found < 0) begin
                    st = STS_NOT_MEMBER;
                end else begin
                    was_holder = (found == turn_pos);
                    for (i = found; i + 1 < roster_len; i++) begin
                        roster[i] = roster[i + 1];
                    end
                    roster_len--;
                    roster[roster_len] = '0;
                    if (roster_len == 0) begin
                        turn_pos = 0;
                        balance = 0;
                    end else if (found < turn_pos) begin
                        turn_pos--;
                    end else if (was_holder) begin
                        if (turn_pos >= roster_len) begin
                            turn_pos = 0;
                        end
                        balance = int'(turn_budget);
                    end
                end
            end
            ACT_CHECK, ACT_SPEND: begin
                st = gate;
                if (st == STS_OK && pts[PTS_W-1]) begin
                    st = STS_BAD_COST;
                end else if (st == STS_OK && int'(pts) > balance) begin
                    st = STS_SHORT;
                end
                if (act == ACT_SPEND && st == STS_OK) begin
                    balance -= int'(pts);
                end
            end
            ACT_END: begin
                st = gate;
                if (st == STS_OK && roster_len != 0) begin
                    turn_pos = (turn_pos + 1) % roster_len;
                    balance = int'(turn_budget);
                end
            end
            default: begin
            end
        endcase
        res.status = st;
        res.slot_user = (int'(idx) < roster_len) ? roster[idx] : '0;
        res.holder_user = (turn_pos < roster_len) ? roster[turn_pos] : '0;
        res.credits_left = CRED_W'(balance);
        res.member_count = CNTO_W'(roster_len);
        res.holder_position = POS_W'(turn_pos);
        return res;
    endfunction

    always @(negedge i_clk) begin : driver
        t_sched_cmd cmd;
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cmd = cmd_queue.pop_front();
                if (cmd.aim_holder) begin
                    cmd.user_id = (turn_pos < roster_len) ? roster[turn_pos] : '0;
                end
                if (cmd.aim_points) begin
                    cmd.points = PTS_W'($urandom_range(balance));
                end
                i_action <= cmd.action;
                i_user_id <= cmd.user_id;
                i_points <= cmd.points;
                i_slot_index <= cmd.slot_index;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_sched_result want;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result beat arrived with no expectation pending");
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_slot_user !== want.slot_user) begin
                        $error("slot_user: expected %0d, got %0d", want.slot_user, o_slot_user);
                        fail_count++;
                    end
                    if (o_holder_user !== want.holder_user) begin
                        $error("holder_user: expected %0d, got %0d",
                               want.holder_user, o_holder_user);
                        fail_count++;
                    end
                    if (o_credits_left !== want.credits_left) begin
                        $error("credits_left: expected %0d, got %0d",
                               want.credits_left, o_credits_left);
                        fail_count++;
                    end
                    if (o_member_count !== want.member_count) begin
                        $error("member_count: expected %0d, got %0d",
                               want.member_count, o_member_count);
                        fail_count++;
                    end
                    if (o_holder_position !== want.holder_position) begin
                        $error("holder_position: expected %0d, got %0d",
                               want.holder_position, o_holder_position);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_q.push_back(apply_command(i_action, i_user_id, i_points,
                                                   i_slot_index));
            end
        end
    end

    task automatic queue_cmd(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] uid,
                             input logic [PTS_W-1:0] pts, input logic [IDX_W-1:0] idx);
        t_sched_cmd cmd;
        cmd.action = act;
        cmd.user_id = uid;
        cmd.points = pts;
        cmd.slot_index = idx;
        cmd.aim_holder = 1'b0;
        cmd.aim_points = 1'b0;
        cmd_queue.push_back(cmd);
    endtask

    // Returns once every beat has been taken and answered and the block has settled.
    task automatic wait_quiet();
        while (cmd_queue.size() != 0 || i_in_valid || expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_budget(input logic [CRED_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        turn_budget = value;
    endtask

    // Mostly traffic from a small id pool, often aimed at the current holder.
    task automatic run_random(input int count);
        t_sched_cmd cmd;
        int         pick;
        int         n;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 18) begin
                cmd.action = ACT_ADD;
            end else if (pick < 34) begin
                cmd.action = ACT_REMOVE;
            end else if (pick < 49) begin
                cmd.action = ACT_CHECK;
            end else if (pick < 69) begin
                cmd.action = ACT_SPEND;
            end else if (pick < 85) begin
                cmd.action = ACT_END;
            end else if (pick < 95) begin
                cmd.action = ACT_READ;
            end else begin
                cmd.action = ACT_W'($urandom_range(7, 6));
            end
            pick = $urandom_range(99);
            if (pick < 85) begin
                cmd.user_id = ID_W'($urandom_range(10, 1));
            end else if (pick < 90) begin
                cmd.user_id = '0;
            end else begin
                cmd.user_id = ID_W'($urandom_range(255));
            end
            cmd.points = ($urandom_range(1) == 0) ? PTS_W'($urandom_range(8))
                                                  : PTS_W'($urandom);
            cmd.slot_index = IDX_W'($urandom_range(7));
            if (cmd.action == ACT_CHECK || cmd.action == ACT_SPEND
                || cmd.action == ACT_END) begin
                cmd.aim_holder = ($urandom_range(99) < 70);
            end else begin
                cmd.aim_holder = (cmd.action == ACT_REMOVE) && ($urandom_range(99) < 30);
            end
            cmd.aim_points = (cmd.action == ACT_CHECK || cmd.action == ACT_SPEND)
                             && ($urandom_range(99) < 60);
            cmd_queue.push_back(cmd);
        end
    endtask

    initial begin
        send_idle_pct = 9;
        recv_idle_pct = 82;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_cmd(ACT_READ, 8'd0, 16'd0, 3'd0);
        queue_cmd(ACT_CHECK, 8'd0, 16'd1, 3'd0);
        queue_cmd(ACT_SPEND, 8'd5, 16'd1, 3'd0);
        queue_cmd(ACT_REMOVE, 8'd0, 16'd0, 3'd0);
        queue_cmd(ACT_REMOVE, 8'd9, 16'd0, 3'd0);
        queue_cmd(ACT_ADD, 8'd0, 16'd0, 3'd0);
        queue_cmd(ACT_ADD, 8'd1, 16'd0, 3'd0);
        queue_cmd(ACT_ADD, 8'd1, 16'd0, 3'd1);
        queue_cmd(ACT_ADD, 8'd255, 16'd0, 3'd1);
        queue_cmd(ACT_ADD, 8'd2, 16'd0, 3'd2);
        queue_cmd(ACT_ADD, 8'd3, 16'd0, 3'd3);
        queue_cmd(ACT_ADD, 8'd4, 16'd0, 3'd4);
        queue_cmd(ACT_ADD, 8'd5, 16'd0, 3'd5);
        queue_cmd(ACT_ADD, 8'd6, 16'd0, 3'd6);
        queue_cmd(ACT_ADD, 8'd7, 16'd0, 3'd7);
        queue_cmd(ACT_ADD, 8'd8, 16'd0, 3'd7);
        queue_cmd(ACT_CHECK, 8'd255, 16'd1, 3'd1);
        queue_cmd(ACT_CHECK, 8'd1, 16'h8000, 3'd0);
        queue_cmd(ACT_SPEND, 8'd1, 16'h7FFF, 3'd0);
        queue_cmd(ACT_SPEND, 8'd1, 16'd4, 3'd0);
        queue_cmd(ACT_END, 8'd1, 16'd0, 3'd1);
        queue_cmd(ACT_REMOVE, 8'd1, 16'd0, 3'd0);
        queue_cmd(ACT_REMOVE, 8'd255, 16'd0, 3'd0);
        queue_cmd(ACT_READ, 8'd0, 16'hFFFF, 3'd7);
        queue_cmd(3'd7, 8'd0, 16'd0, 3'd2);
        wait_quiet();

        write_budget(15'h7FFF);
        run_random(80);
        wait_quiet();
        run_random(80);
        wait_quiet();

        send_idle_pct = 82;
        recv_idle_pct = 9;
        write_budget(15'd0);
        run_random(160);
        wait_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_budget(CRED_W'($urandom_range(40, 1)));
        run_random(80);
        wait_quiet();
        write_budget(15'd3);
        run_random(80);
        wait_quiet();

        if (fail_count == 0) begin
            $display("round_robin_turn_credit_scheduler_core verification clean");
        end else begin
            $display("round_robin_turn_credit_scheduler_core verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("round_robin_turn_credit_scheduler_core verification failed");
        $finish;
    end

endmodule
